/* design/assert_macros.svh */
// assertion helpers included by the top design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// concurrent check on an explicit clock and active-low reset
`define PPTA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// concurrent check on the block clock and reset
`define PPTA_ASSERT(lbl, prop, msg) `PPTA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define PPTA_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define PPTA_ASSERT(lbl, prop, msg)
`endif

`endif

/* design/ppta_pkg.sv */
`timescale 1ns / 1ps

package ppta_pkg;

  // image limits and coordinate format
  localparam int unsigned MAX_DIM         = 4096;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned CFG_FRAC        = 8;

  // field widths
  localparam int unsigned PT_W       = 32;
  localparam int unsigned TEX_W      = 18;
  localparam int unsigned FOC_W      = 24;
  localparam int unsigned IMG_W      = 13;
  localparam int unsigned BPP_W      = 3;
  localparam int unsigned STRIDE_W   = 15;
  localparam int unsigned DEST_W     = 12;
  localparam int unsigned OFF_W      = 26;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // derived datapath widths
  localparam int unsigned QBITS   = $clog2(MAX_DIM);
  localparam int unsigned DIM_W   = QBITS + 1;
  localparam int unsigned NUM_W   = PT_W + FOC_W + 1;
  localparam int unsigned DEN_W   = PT_W - 1 + CFG_FRAC;
  localparam int unsigned REM_W   = DEN_W + QBITS;
  localparam int unsigned TPROD_W = TEX_W + DIM_W + 1;

  // register reset values
  localparam logic [FOC_W-1:0]    RST_CENTER_X = FOC_W'(79379);
  localparam logic [FOC_W-1:0]    RST_CENTER_Y = FOC_W'(64000);
  localparam logic [FOC_W-1:0]    RST_FOCAL_X  = FOC_W'(158348);
  localparam logic [FOC_W-1:0]    RST_FOCAL_Y  = FOC_W'(158348);
  localparam logic [IMG_W-1:0]    RST_WIDTH    = IMG_W'(640);
  localparam logic [IMG_W-1:0]    RST_HEIGHT   = IMG_W'(480);
  localparam logic [BPP_W-1:0]    RST_BPP      = BPP_W'(3);
  localparam logic [STRIDE_W-1:0] RST_STRIDE   = STRIDE_W'(1920);

  // register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_FOCAL_X      = 3'd2,
    REG_FOCAL_Y      = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5,
    REG_BYTES_PP     = 3'd6,
    REG_ROW_STRIDE   = 3'd7
  } ppta_reg_e;

  // zero acts as one, oversize acts as the largest image
  function automatic logic [DIM_W-1:0] dim_of(input logic [IMG_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (r > IMG_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(r);
    end
    return d;
  endfunction

endpackage

/* design/ppta_if.sv */
`timescale 1ns / 1ps

// point and texture coordinate channel
interface ppta_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppta_pkg::PT_W-1:0]    point_x;
  logic signed [ppta_pkg::PT_W-1:0]    point_y;
  logic signed [ppta_pkg::PT_W-1:0]    point_z;
  logic signed [ppta_pkg::TEX_W-1:0]   tex_u;
  logic signed [ppta_pkg::TEX_W-1:0]   tex_v;

  modport source (output valid, point_x, point_y, point_z, tex_u, tex_v, input ready);
  modport sink   (input valid, point_x, point_y, point_z, tex_u, tex_v, output ready);
endinterface

// projected pixel and texel address channel
interface ppta_out_if;
  logic                          valid;
  logic                          ready;
  logic [ppta_pkg::DEST_W-1:0]   dest_x;
  logic [ppta_pkg::DEST_W-1:0]   dest_y;
  logic [ppta_pkg::OFF_W-1:0]    texel_offset;
  logic                          depth_valid;

  modport source (output valid, dest_x, dest_y, texel_offset, depth_valid, input ready);
  modport sink   (input valid, dest_x, dest_y, texel_offset, depth_valid, output ready);
endinterface

// register write channel
interface ppta_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ppta_pkg::CFG_IDX_W-1:0]    index;
  logic [ppta_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/ppta_div.sv */
`timescale 1ns / 1ps

module ppta_div (
  input  logic                           clk_i,
  input  logic [ppta_pkg::QBITS-1:0]     en_i,
  input  logic [ppta_pkg::REM_W-1:0]     rem_i,
  input  logic [ppta_pkg::DEN_W-1:0]     den_i,
  output logic [ppta_pkg::QBITS-1:0]     quo_o
);
  import ppta_pkg::*;

  // per-stage partial remainder, divisor and quotient
  logic [REM_W-1:0] rem_q [QBITS-1];
  logic [DEN_W-1:0] den_q [QBITS-1];
  logic [QBITS-1:0] quo_q [QBITS];

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < QBITS; k++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] trial;
    logic [DEN_W-1:0] den_in;
    logic [QBITS-1:0] quo_in;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = REM_W'(den_in) << (QBITS - 1 - k);
    assign take  = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        quo_q[k] <= {quo_in[QBITS-2:0], take};
      end
    end

    // the last stage keeps only the quotient
    if (k < QBITS - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[k]) begin
          rem_q[k] <= take ? (rem_in - trial) : rem_in;
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QBITS-1];

endmodule

/* design/point_projection_texture_address_top.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Pinhole projection of depth points with texture addressing. One point is
// taken per clock and each point gives one result after passing a multiply
// stage, an add and texel stage, a range check and offset multiply stage, 12
// quotient stages (one bit of the pixel coordinate per stage, so the
// divider depth follows the image size limit), and the output register. Every
// stage has its own valid bit and holds under backpressure while empty stages
// upstream keep filling, so throughput stays at one point per clock whenever
// the sink takes results. Registers may be written only while no point is in
// flight; they reset to a 640x480, 3 byte per pixel setup and need no clear.
module point_projection_texture_address_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  ppta_in_if.sink    pt_i,
  ppta_out_if.source res_o,
  ppta_cfg_if.sink   cfg_i
);
  import ppta_pkg::*;

  localparam int unsigned S_MUL = 0;
  localparam int unsigned S_ADD = 1;
  localparam int unsigned S_CMP = 2;
  localparam int unsigned S_DIV = 3;
  localparam int unsigned NSTG  = S_DIV + QBITS + 1;
  localparam int unsigned S_OUT = NSTG - 1;

  // configuration registers
  logic [FOC_W-1:0]    center_x_q, center_y_q, focal_x_q, focal_y_q;
  logic [IMG_W-1:0]    img_w_q, img_h_q;
  logic [BPP_W-1:0]    bpp_q;
  logic [STRIDE_W-1:0] stride_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= RST_CENTER_X;
      center_y_q <= RST_CENTER_Y;
      focal_x_q  <= RST_FOCAL_X;
      focal_y_q  <= RST_FOCAL_Y;
      img_w_q    <= RST_WIDTH;
      img_h_q    <= RST_HEIGHT;
      bpp_q      <= RST_BPP;
      stride_q   <= RST_STRIDE;
    end else if (cfg_i.valid) begin
      unique case (ppta_reg_e'(cfg_i.index))
        REG_CENTER_X:     center_x_q <= cfg_i.data[FOC_W-1:0];
        REG_CENTER_Y:     center_y_q <= cfg_i.data[FOC_W-1:0];
        REG_FOCAL_X:      focal_x_q  <= cfg_i.data[FOC_W-1:0];
        REG_FOCAL_Y:      focal_y_q  <= cfg_i.data[FOC_W-1:0];
        REG_IMAGE_WIDTH:  img_w_q    <= cfg_i.data[IMG_W-1:0];
        REG_IMAGE_HEIGHT: img_h_q    <= cfg_i.data[IMG_W-1:0];
        REG_BYTES_PP:     bpp_q      <= cfg_i.data[BPP_W-1:0];
        REG_ROW_STRIDE:   stride_q   <= cfg_i.data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective image size
  logic [DIM_W-1:0] dim_w, dim_h;
  assign dim_w = dim_of(img_w_q);
  assign dim_h = dim_of(img_h_q);

  // rounded texel index clamped to the image
  function automatic logic [QBITS-1:0] texel(input logic signed [TPROD_W-1:0] prod,
                                             input logic [DIM_W-1:0] dim);
    logic [TPROD_W:0]                 t;
    logic [TPROD_W-COORD_FRAC_BITS:0] s;
    logic [TPROD_W-COORD_FRAC_BITS:0] lim;
    logic [QBITS-1:0]                 r;
    t   = (TPROD_W+1)'(prod) + ((TPROD_W+1)'(1) << (COORD_FRAC_BITS - 1));
    s   = t[TPROD_W:COORD_FRAC_BITS];
    lim = (TPROD_W-COORD_FRAC_BITS+1)'(dim - DIM_W'(1));
    if (t[TPROD_W]) begin
      r = '0;
    end else if (s > lim) begin
      r = QBITS'(lim);
    end else begin
      r = QBITS'(s);
    end
    return r;
  endfunction

  // quotient clamped to size minus one
  function automatic logic [DEST_W-1:0] clamp_q(input logic [QBITS-1:0] q,
                                                input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0]  lim;
    logic [DEST_W-1:0] r;
    lim = dim - DIM_W'(1);
    if (DIM_W'(q) > lim) begin
      r = DEST_W'(lim);
    end else begin
      r = DEST_W'(q);
    end
    return r;
  endfunction

  // stage valid bits and ready chain
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_in;
  logic [NSTG-1:0] rdy;

  assign vld_in = {vld_q[NSTG-2:0], pt_i.valid};

  always_comb begin
    rdy[NSTG-1] = !vld_q[NSTG-1] || res_o.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
  end

  assign pt_i.ready = rdy[S_MUL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_q[i] <= vld_in[i];
        end
      end
    end
  end

  // multiply stage: focal and center products, texture scaling
  logic signed [NUM_W-1:0]   mfx_q, mfy_q, mcx_q, mcy_q;
  logic signed [TPROD_W-1:0] tu_q, tv_q;
  logic [DEN_W-1:0]          den0_q;
  logic                      dv0_q;

  always_ff @(posedge clk_i) begin
    if (rdy[S_MUL]) begin
      mfx_q  <= pt_i.point_x * $signed({1'b0, focal_x_q});
      mfy_q  <= pt_i.point_y * $signed({1'b0, focal_y_q});
      mcx_q  <= $signed({1'b0, center_x_q}) * pt_i.point_z;
      mcy_q  <= $signed({1'b0, center_y_q}) * pt_i.point_z;
      tu_q   <= pt_i.tex_u * $signed({1'b0, dim_w});
      tv_q   <= pt_i.tex_v * $signed({1'b0, dim_h});
      den0_q <= {pt_i.point_z[PT_W-2:0], {CFG_FRAC{1'b0}}};
      dv0_q  <= !pt_i.point_z[PT_W-1] && (pt_i.point_z != '0);
    end
  end

  // add stage: numerators and texel indices
  logic signed [NUM_W-1:0] numx_q, numy_q;
  logic [QBITS-1:0]        tx_q, ty_q;
  logic [DEN_W-1:0]        den1_q;
  logic                    dv1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[S_ADD]) begin
      numx_q <= mfx_q + mcx_q;
      numy_q <= mfy_q + mcy_q;
      tx_q   <= texel(tu_q, dim_w);
      ty_q   <= texel(tv_q, dim_h);
      den1_q <= den0_q;
      dv1_q  <= dv0_q;
    end
  end

  // range stage: negative goes to zero, beyond the divider range saturates
  logic [NUM_W-1:0]          lim_num;
  logic                      negx, negy, satx, saty;
  logic [REM_W-1:0]          remx_q, remy_q;
  logic [DEN_W-1:0]          den2_q;
  logic                      satx2_q, saty2_q, dv2_q;
  logic [QBITS+BPP_W-1:0]    offx_q;
  logic [QBITS+STRIDE_W-1:0] offy_q;

  assign lim_num = NUM_W'({den1_q, {QBITS{1'b0}}});
  assign negx    = numx_q[NUM_W-1] || (numx_q == '0);
  assign negy    = numy_q[NUM_W-1] || (numy_q == '0);
  assign satx    = !negx && ($unsigned(numx_q) >= lim_num);
  assign saty    = !negy && ($unsigned(numy_q) >= lim_num);

  always_ff @(posedge clk_i) begin
    if (rdy[S_CMP]) begin
      remx_q  <= (negx || satx) ? '0 : numx_q[REM_W-1:0];
      remy_q  <= (negy || saty) ? '0 : numy_q[REM_W-1:0];
      den2_q  <= den1_q;
      satx2_q <= satx;
      saty2_q <= saty;
      dv2_q   <= dv1_q;
      offx_q  <= tx_q * bpp_q;
      offy_q  <= ty_q * stride_q;
    end
  end

  // quotient pipelines, one per axis
  logic [QBITS-1:0] quox, quoy;

  ppta_div u_div_x (
    .clk_i (clk_i),
    .en_i  (rdy[S_DIV +: QBITS]),
    .rem_i (remx_q),
    .den_i (den2_q),
    .quo_o (quox)
  );

  ppta_div u_div_y (
    .clk_i (clk_i),
    .en_i  (rdy[S_DIV +: QBITS]),
    .rem_i (remy_q),
    .den_i (den2_q),
    .quo_o (quoy)
  );

  // side data riding along with the quotient stages
  logic             satx_q [QBITS];
  logic             saty_q [QBITS];
  logic             dv_q   [QBITS];
  logic [OFF_W-1:0] off_q  [QBITS];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QBITS; k++) begin
      if (rdy[S_DIV + k]) begin
        if (k == 0) begin
          satx_q[k] <= satx2_q;
          saty_q[k] <= saty2_q;
          dv_q[k]   <= dv2_q;
          off_q[k]  <= OFF_W'(offx_q) + OFF_W'(offy_q);
        end else begin
          satx_q[k] <= satx_q[k-1];
          saty_q[k] <= saty_q[k-1];
          dv_q[k]   <= dv_q[k-1];
          off_q[k]  <= off_q[k-1];
        end
      end
    end
  end

  // output register
  logic [DEST_W-1:0] dest_x_q, dest_y_q;
  logic [OFF_W-1:0]  off_out_q;
  logic              dv_out_q;

  always_ff @(posedge clk_i) begin
    if (rdy[S_OUT]) begin
      dest_x_q  <= dv_q[QBITS-1]
                   ? clamp_q(satx_q[QBITS-1] ? '1 : quox, dim_w) : '0;
      dest_y_q  <= dv_q[QBITS-1]
                   ? clamp_q(saty_q[QBITS-1] ? '1 : quoy, dim_h) : '0;
      off_out_q <= off_q[QBITS-1];
      dv_out_q  <= dv_q[QBITS-1];
    end
  end

  assign res_o.valid        = vld_q[S_OUT];
  assign res_o.dest_x       = dest_x_q;
  assign res_o.dest_y       = dest_y_q;
  assign res_o.texel_offset = off_out_q;
  assign res_o.depth_valid  = dv_out_q;

  // checks
  `PPTA_ASSERT(a_no_depth_zero_dest, res_o.valid && !res_o.depth_valid |-> res_o.dest_x == '0 && res_o.dest_y == '0, "point behind camera gave a nonzero pixel")
  `PPTA_ASSERT(a_dest_x_in_image, res_o.valid |-> DIM_W'(res_o.dest_x) < dim_w, "column outside the image")
  `PPTA_ASSERT(a_dest_y_in_image, res_o.valid |-> DIM_W'(res_o.dest_y) < dim_h, "row outside the image")
  `PPTA_ASSERT(a_sink_ready_flows, res_o.ready |-> pt_i.ready, "pipeline stalled with sink ready")
  `PPTA_ASSERT(a_transfer_enters, pt_i.valid && pt_i.ready |=> vld_q[S_MUL], "accepted point lost at entry")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ppta_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned ERROR_LIMIT  = 50;
  localparam int unsigned LONG_STALL   = 80;
  localparam int unsigned DRAIN_CYCLES = 24;

  // one depth point with its texture coordinate
  typedef struct {
    logic signed [PT_W-1:0]  x;
    logic signed [PT_W-1:0]  y;
    logic signed [PT_W-1:0]  z;
    logic signed [TEX_W-1:0] u;
    logic signed [TEX_W-1:0] v;
  } point_t;

  // projected pixel and texel address
  typedef struct {
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;
    logic [OFF_W-1:0]  texel_offset;
    logic              depth_valid;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ppta_in_if  pt_if ();
  ppta_out_if res_if ();
  ppta_cfg_if cfg_if ();

  point_projection_texture_address_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_i   (pt_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the camera and texture setup
  logic [FOC_W-1:0]    cam_center_x = RST_CENTER_X;
  logic [FOC_W-1:0]    cam_center_y = RST_CENTER_Y;
  logic [FOC_W-1:0]    cam_focal_x  = RST_FOCAL_X;
  logic [FOC_W-1:0]    cam_focal_y  = RST_FOCAL_Y;
  logic [IMG_W-1:0]    img_width    = RST_WIDTH;
  logic [IMG_W-1:0]    img_height   = RST_HEIGHT;
  logic [BPP_W-1:0]    tex_bpp      = RST_BPP;
  logic [STRIDE_W-1:0] tex_stride   = RST_STRIDE;

  point_t point_queue[$];
  pixel_t projected_queue[$];
  point_t point_on_bus;

  int unsigned points_pushed   = 0;
  int unsigned points_accepted = 0;
  int unsigned pixels_checked  = 0;
  int unsigned reg_writes      = 0;
  int unsigned setups_run      = 0;
  int unsigned errors          = 0;
  int unsigned stall_requests  = 0;
  int unsigned stall_served    = 0;
  bit          sender_idle_en   = 1'b0;
  bit          receiver_idle_en = 1'b0;

  // usable image size: zero acts as one, oversize acts as the limit
  function automatic longint usable_dim(logic [IMG_W-1:0] r);
    if (r == '0) return 1;
    if (r > MAX_DIM) return MAX_DIM;
    return longint'(r);
  endfunction

  function automatic longint clamp_to(longint q, longint dim);
    if (q < 0) return 0;
    if (q > dim - 1) return dim - 1;
    return q;
  endfunction

  // exact pinhole projection on one axis, truncated toward zero
  function automatic longint project_axis(logic signed [PT_W-1:0] p, logic signed [PT_W-1:0] z,
                                          logic [FOC_W-1:0] focal, logic [FOC_W-1:0] center,
                                          longint dim);
    longint num;
    longint den;
    num = longint'(p) * longint'(focal) + longint'(center) * longint'(z);
    den = longint'(z) * 256;
    return clamp_to(num / den, dim);
  endfunction

  // rounded texture pixel, negative sums go to zero
  function automatic longint texel_index(logic signed [TEX_W-1:0] c, longint dim);
    longint t;
    t = longint'(c) * dim + (longint'(1) << (COORD_FRAC_BITS - 1));
    if (t < 0) return 0;
    return clamp_to(t >>> COORD_FRAC_BITS, dim);
  endfunction

  function automatic pixel_t project_point(point_t p);
    pixel_t r;
    longint w;
    longint h;
    longint tx;
    longint ty;
    w = usable_dim(img_width);
    h = usable_dim(img_height);
    r.dest_x      = '0;
    r.dest_y      = '0;
    r.depth_valid = 1'b0;
    if (p.z > 0) begin
      r.dest_x      = DEST_W'(project_axis(p.x, p.z, cam_focal_x, cam_center_x, w));
      r.dest_y      = DEST_W'(project_axis(p.y, p.z, cam_focal_y, cam_center_y, h));
      r.depth_valid = 1'b1;
    end
    tx = texel_index(p.u, w);
    ty = texel_index(p.v, h);
    r.texel_offset = OFF_W'(tx * longint'(tex_bpp) + ty * longint'(tex_stride));
    return r;
  endfunction

  function automatic point_t make_point(logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                                        logic signed [PT_W-1:0] z, logic signed [TEX_W-1:0] u,
                                        logic signed [TEX_W-1:0] v);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.u = u;
    p.v = v;
    return p;
  endfunction

  // mostly plausible scene points, some raw noise and bad depths
  function automatic point_t rand_point();
    point_t      p;
    int unsigned kind;
    int          zz;
    int          ox;
    int          oy;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      zz = int'($urandom_range(6554, 655360));
      ox = int'($urandom_range(0, 2 * zz)) - zz;
      oy = int'($urandom_range(0, 2 * zz)) - zz;
      p  = make_point(ox, oy, zz, TEX_W'($urandom_range(0, 65536)),
                      TEX_W'($urandom_range(0, 65536)));
    end else if (kind == 6) begin
      // very near depth, tiny denominators
      p = make_point($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
                     $urandom_range(1, 255), TEX_W'($urandom), TEX_W'($urandom));
    end else if (kind == 7) begin
      // depth at or behind the camera
      p = make_point($urandom, $urandom, -int'($urandom_range(0, 655360)),
                     TEX_W'($urandom), TEX_W'($urandom));
    end else begin
      p = make_point($urandom, $urandom, $urandom, TEX_W'($urandom), TEX_W'($urandom));
    end
    return p;
  endfunction

  // input driver
  int unsigned send_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_if.valid   <= 1'b0;
      pt_if.point_x <= '0;
      pt_if.point_y <= '0;
      pt_if.point_z <= '0;
      pt_if.tex_u   <= '0;
      pt_if.tex_v   <= '0;
      send_gap = 0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        projected_queue.push_back(project_point(point_on_bus));
        points_accepted++;
        send_gap = sender_idle_en ? $urandom_range(0, 3) : 0;
      end
      if (!pt_if.valid || pt_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pt_if.valid <= 1'b0;
        end else if (point_queue.size() > 0) begin
          point_on_bus = point_queue.pop_front();
          pt_if.point_x <= point_on_bus.x;
          pt_if.point_y <= point_on_bus.y;
          pt_if.point_z <= point_on_bus.z;
          pt_if.tex_u   <= point_on_bus.u;
          pt_if.tex_v   <= point_on_bus.v;
          pt_if.valid   <= 1'b1;
        end else begin
          pt_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  int unsigned recv_wait;
  int unsigned recv_hold;
  pixel_t      want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      recv_wait = 0;
      recv_hold = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (projected_queue.size() == 0) begin
          $error("result transfer with no point outstanding");
          errors++;
        end else begin
          want = projected_queue.pop_front();
          if (res_if.dest_x !== want.dest_x) begin
            $error("dest_x: expected %0d, got %0d", want.dest_x, res_if.dest_x);
            errors++;
          end
          if (res_if.dest_y !== want.dest_y) begin
            $error("dest_y: expected %0d, got %0d", want.dest_y, res_if.dest_y);
            errors++;
          end
          if (res_if.texel_offset !== want.texel_offset) begin
            $error("texel_offset: expected %0d, got %0d", want.texel_offset,
                   res_if.texel_offset);
            errors++;
          end
          if (res_if.depth_valid !== want.depth_valid) begin
            $error("depth_valid: expected %0d, got %0d", want.depth_valid,
                   res_if.depth_valid);
            errors++;
          end
        end
        pixels_checked++;
        recv_wait = receiver_idle_en ? $urandom_range(0, 3) : 0;
      end
      if (stall_served != stall_requests) begin
        stall_served++;
        recv_hold = LONG_STALL;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        res_if.ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transfer, and a cap on mismatches
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (errors >= ERROR_LIMIT) begin
        $display("stopping after %0d mismatches", errors);
        $display("TEST FAILED");
        $finish;
      end else if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready) ||
                   (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_point(point_t p);
    point_queue.push_back(p);
    points_pushed++;
  endtask

  // sender pause: every pushed point has come back as a result
  task automatic wait_drained();
    while (pixels_checked != points_pushed) @(negedge clk_i);
  endtask

  task automatic write_reg(ppta_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_CENTER_X:     cam_center_x = val;
      REG_CENTER_Y:     cam_center_y = val;
      REG_FOCAL_X:      cam_focal_x  = val;
      REG_FOCAL_Y:      cam_focal_y  = val;
      REG_IMAGE_WIDTH:  img_width    = val[IMG_W-1:0];
      REG_IMAGE_HEIGHT: img_height   = val[IMG_W-1:0];
      REG_BYTES_PP:     tex_bpp      = val[BPP_W-1:0];
      REG_ROW_STRIDE:   tex_stride   = val[STRIDE_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic load_setup(logic [FOC_W-1:0] cx, logic [FOC_W-1:0] cy, logic [FOC_W-1:0] fx,
                            logic [FOC_W-1:0] fy, logic [IMG_W-1:0] w, logic [IMG_W-1:0] h,
                            logic [BPP_W-1:0] bpp, logic [STRIDE_W-1:0] stride);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_BYTES_PP, CFG_DATA_W'(bpp));
    write_reg(REG_ROW_STRIDE, CFG_DATA_W'(stride));
    setups_run++;
  endtask

  // random camera, mostly small images
  task automatic load_random_setup();
    logic [IMG_W-1:0] w;
    logic [IMG_W-1:0] h;
    w = ($urandom_range(0, 3) == 0) ? IMG_W'($urandom_range(1, MAX_DIM))
                                    : IMG_W'($urandom_range(1, 64));
    h = ($urandom_range(0, 3) == 0) ? IMG_W'($urandom_range(1, MAX_DIM))
                                    : IMG_W'($urandom_range(1, 64));
    load_setup(FOC_W'($urandom_range(0, w * 256)), FOC_W'($urandom_range(0, h * 256)),
               FOC_W'($urandom), FOC_W'($urandom), w, h,
               BPP_W'($urandom_range(1, 4)), STRIDE_W'($urandom_range(1, 16384)));
  endtask

  // random points in chunks, idling switched per chunk
  task automatic random_points(int unsigned count);
    int unsigned done;
    int unsigned chunk;
    done = 0;
    while (done < count) begin
      chunk = $urandom_range(5, 30);
      if (chunk > count - done) chunk = count - done;
      sender_idle_en   = ($urandom_range(0, 2) != 0);
      receiver_idle_en = ($urandom_range(0, 2) != 0);
      repeat (chunk) begin
        push_point(rand_point());
        done++;
      end
      while (point_queue.size() != 0) @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = REG_CENTER_X;
    cfg_if.data         = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed points on the reset camera
    setups_run = 1;
    push_point(make_point(0, 0, 65536, 0, 0));
    push_point(make_point(65536, 65536, 65536, 65536, 65536));
    push_point(make_point(0, 0, 0, 0, 0));
    push_point(make_point(100, 100, -1, -131072, -131072));
    push_point(make_point(32'h7FFFFFFF, 32'h7FFFFFFF, 1, 131071, 131071));
    push_point(make_point(32'h80000000, 32'h80000000, 1, -1, -1));
    push_point(make_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0));
    push_point(make_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 65535, 32768));
    push_point(make_point(-65536, -65536, 131072, 32768, 32768));
    push_point(make_point(32'h55555555, 32'hAAAAAAAA, 32'h0000FFFF, 18'h15555, 18'h2AAAA));
    push_point(make_point(32'hAAAAAAAA, 32'h55555555, 32'h7FFF0000, 18'h2AAAA, 18'h15555));
    // texel sum just below and just above zero
    push_point(make_point(-1, -1, 1, -52, -52));
    push_point(make_point(1, 1, 1, -51, -51));
    push_point(make_point(-32768, 32768, 65536, 98304, -65536));
    push_point(make_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 18'h3FFFF, 18'h3FFFF));
    wait_drained();

    // long receiver stall while the sender keeps offering
    sender_idle_en   = 1'b0;
    receiver_idle_en = 1'b0;
    stall_requests++;
    repeat (60) push_point(rand_point());
    wait_drained();
    random_points(70);

    // camera registers at their top values, image at the size limit
    load_setup('1, '1, '1, '1, IMG_W'(MAX_DIM), IMG_W'(MAX_DIM), BPP_W'(4), STRIDE_W'(16384));
    random_points(70);

    // camera registers at zero, image size, bytes and stride at one
    load_setup('0, '0, '0, '0, IMG_W'(1), IMG_W'(1), BPP_W'(1), STRIDE_W'(1));
    random_points(50);

    // zero width, oversize height, offset wrapping past 26 bits
    load_setup(FOC_W'(24'h123456), FOC_W'(24'h654321), FOC_W'(24'hABCDEF), FOC_W'(24'h0F0F0F),
               '0, '1, '1, '1);
    push_point(make_point(0, 0, 65536, 131071, 131071));
    push_point(make_point(0, 0, -5, 65536, 65535));
    random_points(70);

    // width above the limit, zero height, zero bytes and stride
    load_setup(FOC_W'(80000), FOC_W'(0), FOC_W'(100000), FOC_W'(300000), IMG_W'(5000), '0,
               '0, '0);
    random_points(50);

    repeat (4) begin
      load_random_setup();
      random_points(55);
    end

    load_setup(RST_CENTER_X, RST_CENTER_Y, RST_FOCAL_X, RST_FOCAL_Y, RST_WIDTH, RST_HEIGHT,
               RST_BPP, RST_STRIDE);
    random_points(60);

    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (projected_queue.size() != 0) begin
      $error("%0d projected points never came out", projected_queue.size());
      errors++;
    end

    $display("%0d points projected and %0d results checked", points_accepted, pixels_checked);
    $display("%0d register writes over %0d camera setups", reg_writes, setups_run);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* point_projection_texture_address_top.f */
+incdir+design
design/ppta_pkg.sv
design/ppta_if.sv
design/ppta_div.sv
design/point_projection_texture_address_top.sv
test/tb_top.sv
